/* sv/tgasd_pkg.sv */
// shared types, codes and the pixel conversion for the tga stream decoder
// used by the row divider and the top level; depends on nothing else
`default_nettype none

package tgasd_pkg;

   // parser phase
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_SKIPID,
      PH_PKTHDR,
      PH_PIXEL,
      PH_DONE
   } tgasd_phase_type;

   // result kind carried on tuser
   typedef enum logic [1:0] {
      STATUS_PIXEL    = 2'd0,
      STATUS_BAD_TYPE = 2'd1,
      STATUS_BAD_BPP  = 2'd2,
      STATUS_CMAP     = 2'd3
   } tgasd_status_type;

   // header layout
   localparam logic [7:0] HDR_ID_LENGTH = 8'd0;
   localparam logic [7:0] HDR_CMAP_KIND = 8'd1;
   localparam logic [7:0] HDR_IMG_TYPE  = 8'd2;
   localparam logic [7:0] HDR_WIDTH_LO  = 8'd12;
   localparam logic [7:0] HDR_WIDTH_HI  = 8'd13;
   localparam logic [7:0] HDR_HEIGHT_LO = 8'd14;
   localparam logic [7:0] HDR_HEIGHT_HI = 8'd15;
   localparam logic [7:0] HDR_DEPTH     = 8'd16;
   localparam logic [7:0] HDR_DESC      = 8'd17;
   localparam logic [7:0] HDR_LENGTH    = 8'd18;

   localparam int unsigned DESC_TOP_DOWN_BIT = 5;

   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] TYPE_RLE = 8'd10;

   localparam logic [7:0] DEPTH_16 = 8'd16;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   // request to the row divider
   typedef struct packed {
      logic        start;
      logic [16:0] dividend;
      logic [15:0] divisor;
   } tgasd_div_req_type;

   // answer of the row divider
   typedef struct packed {
      logic        busy;
      logic        done;
      logic [7:0]  quotient;
      logic [15:0] remainder;
   } tgasd_div_rsp_type;

   // one decoded result
   typedef struct packed {
      tgasd_status_type status;
      logic [31:0]      pixel_argb;
      logic [15:0]      pos_x;
      logic [15:0]      pos_y;
      logic [7:0]       repeat_res;
      logic             last;
   } tgasd_result_type;

   // argb8888 from the stored low bytes and the final byte of a pixel
   function automatic logic [31:0] convert_pixel(input logic [7:0]  depth,
                                                 input logic [23:0] low_bytes,
                                                 input logic [7:0]  final_byte);
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [31:0] px;
      b0 = low_bytes[7:0];
      b1 = low_bytes[15:8];
      b2 = low_bytes[23:16];
      if (depth == DEPTH_16) begin
         px = {ALPHA_OPAQUE, final_byte[6:2], 3'b000,
               final_byte[1:0], b0[7:5], 3'b000, b0[4:0], 3'b000};
      end else if (depth == DEPTH_24) begin
         px = {ALPHA_OPAQUE, final_byte, b1, b0};
      end else if (final_byte == 8'd0) begin
         px = 32'd0;
      end else begin
         px = {final_byte, b2, b1, b0};
      end
      return px;
   endfunction

endpackage

`default_nettype wire

/* sv/tgasd_row_div.sv */
// row divider: splits a column sum into whole rows and the column left over
// restoring division, two quotient bits a cycle; uses tgasd_pkg
`default_nettype none

module tgasd_row_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tgasd_pkg::tgasd_div_req_type div_req,
   output tgasd_pkg::tgasd_div_rsp_type      div_rsp
);

   logic        active_ff, active_in;
   logic        done_ff, done_in;
   logic [1:0]  count_ff, count_in;
   logic [16:0] rem_ff, rem_in;
   logic [23:0] den_ff, den_in;
   logic [7:0]  quo_ff, quo_in;

   logic [23:0] rem_a;
   logic [23:0] rem_b;
   logic [23:0] den_b;
   logic        bit_a;
   logic        bit_b;

   always_comb begin
      // first step against den, second against den / 2
      rem_a = {7'd0, rem_ff};
      bit_a = (rem_a >= den_ff);
      if (bit_a) begin
         rem_a = rem_a - den_ff;
      end
      den_b = den_ff >> 1;
      bit_b = (rem_a >= den_b);
      rem_b = bit_b ? (rem_a - den_b) : rem_a;
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      if (div_req.start) begin
         active_in = 1'b1;
         count_in  = 2'd0;
         rem_in    = div_req.dividend;
         den_in    = {1'b0, div_req.divisor, 7'd0};
         quo_in    = 8'd0;
      end else if (active_ff) begin
         rem_in   = rem_b[16:0];
         den_in   = den_ff >> 2;
         quo_in   = {quo_ff[5:0], bit_a, bit_b};
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd3) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy      = active_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff[15:0];

endmodule

`default_nettype wire

/* sv/tga_image_stream_decoder.sv */
// top level of the tga stream decoder: header parser, rle unpacker, pixel
// conversion and output skid stage; uses tgasd_pkg and tgasd_row_div
//
// usage
//  req channel: one file byte per transfer on req_tdata, req_tuser high on
//  the first byte of a file (restarts the parser at any time)
//  rsp channel: one transfer per pixel result or per header error; the kind
//  is on rsp_tuser, rsp_tlast marks the final pixel of the image or an error
//  output: a result is registered in the output stage before it is on rsp
//  throughput: one byte per cycle while req_tready is high; after an rle run that
//  crosses more than one row end, req_tready drops while the row divider (two
//  quotient bits per cycle, four passes, then a cursor update) moves the cursor
//  bytes before a file start, after an error and after the last pixel are
//  taken and dropped
//  reset: synchronous, active high; the parser waits for a file start and
//  both output registers are emptied
//  stall: a result that finds rsp_tvalid high and rsp_tready low goes to a
//  skid register; req_tready is also low while that register is full
`default_nettype none

module tga_image_stream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic [0:0]  req_tuser,   // file_start
   // results
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [71:0] rsp_tdata,   // pixel_argb, pos_x, pos_y, repeat_res
   output      logic [1:0]  rsp_tuser,   // status
   output      logic        rsp_tlast    // last
);

   // parser state
   tgasd_pkg::tgasd_phase_type phase_ff, phase_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  id_length_ff, id_length_in;
   logic [7:0]  colormap_kind_ff, colormap_kind_in;
   logic [7:0]  image_type_ff, image_type_in;
   logic [7:0]  pixel_depth_ff, pixel_depth_in;
   logic        top_down_ff, top_down_in;
   logic [15:0] image_width_ff, image_width_in;
   logic [15:0] image_height_ff, image_height_in;
   logic [23:0] pixel_bytes_ff, pixel_bytes_in;
   logic [1:0]  pixel_byte_count_ff, pixel_byte_count_in;
   logic        packet_repeat_ff, packet_repeat_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic [15:0] cur_x_ff, cur_x_in;
   logic [15:0] cur_y_ff, cur_y_in;
   logic [31:0] pixels_left_ff, pixels_left_in;

   // output register and skid
   logic                         out_valid_ff, out_valid_in;
   tgasd_pkg::tgasd_result_type  out_data_ff, out_data_in;
   logic                         skid_valid_ff, skid_valid_in;
   tgasd_pkg::tgasd_result_type  skid_data_ff, skid_data_in;

   // decode of the accepted byte
   logic                         acc;
   logic                         pop;
   tgasd_pkg::tgasd_phase_type   ph_eff;
   logic [7:0]                   bi_eff;
   logic [7:0]                   bi_next;
   logic                         hdr_end;
   tgasd_pkg::tgasd_status_type  hdr_err;
   logic                         image_empty;
   logic                         is_rle;
   tgasd_pkg::tgasd_phase_type   data_phase;
   logic                         skip_done;
   logic [2:0]                   pix_size;
   logic                         pix_final;
   logic [7:0]                   run_len;
   logic                         run_last;
   logic [7:0]                   pkt_dec;
   logic [16:0]                  col_sum;
   logic [16:0]                  col_wrap;
   logic [16:0]                  width_ext;

   logic                         res_valid;
   tgasd_pkg::tgasd_result_type  res;

   tgasd_pkg::tgasd_div_req_type div_req;
   tgasd_pkg::tgasd_div_rsp_type div_rsp;

   tgasd_row_div u_row_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // hold input while the cursor is being moved or the skid is full
   assign req_tready = !div_rsp.busy && !div_rsp.done && !skid_valid_ff;
   assign acc        = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   always_comb begin
      ph_eff  = req_tuser[0] ? tgasd_pkg::PH_HEADER : phase_ff;
      bi_eff  = req_tuser[0] ? 8'd0 : byte_index_ff;
      bi_next = bi_eff + 8'd1;
      hdr_end = (bi_next == tgasd_pkg::HDR_LENGTH);

      // checks in order: type, depth, colour map
      if (image_type_ff != tgasd_pkg::TYPE_RAW && image_type_ff != tgasd_pkg::TYPE_RLE) begin
         hdr_err = tgasd_pkg::STATUS_BAD_TYPE;
      end else if (pixel_depth_ff != tgasd_pkg::DEPTH_16 &&
                   pixel_depth_ff != tgasd_pkg::DEPTH_24 &&
                   pixel_depth_ff != tgasd_pkg::DEPTH_32) begin
         hdr_err = tgasd_pkg::STATUS_BAD_BPP;
      end else if (colormap_kind_ff != 8'd0) begin
         hdr_err = tgasd_pkg::STATUS_CMAP;
      end else begin
         hdr_err = tgasd_pkg::STATUS_PIXEL;
      end

      image_empty = (image_width_ff == 16'd0) || (image_height_ff == 16'd0);
      is_rle      = (image_type_ff == tgasd_pkg::TYPE_RLE);
      data_phase  = is_rle ? tgasd_pkg::PH_PKTHDR : tgasd_pkg::PH_PIXEL;
      skip_done   = (bi_next == id_length_ff);

      if (pixel_depth_ff == tgasd_pkg::DEPTH_16) begin
         pix_size = 3'd2;
      end else if (pixel_depth_ff == tgasd_pkg::DEPTH_24) begin
         pix_size = 3'd3;
      end else begin
         pix_size = 3'd4;
      end
      pix_final = !(({1'b0, pixel_byte_count_ff} + 3'd1) < pix_size);

      // run length: clipped to the pixels left, never zero
      if (is_rle && packet_repeat_ff) begin
         if (pixels_left_ff < {24'd0, packet_left_ff}) begin
            run_len = pixels_left_ff[7:0];
         end else begin
            run_len = packet_left_ff;
         end
      end else begin
         run_len = 8'd1;
      end
      if (run_len == 8'd0) begin
         run_len = 8'd1;
      end
      run_last = (pixels_left_ff <= {24'd0, run_len});
      pkt_dec  = packet_left_ff - 8'd1;

      width_ext = {1'b0, image_width_ff};
      col_sum   = {1'b0, cur_x_ff} + {9'd0, run_len};
      col_wrap  = col_sum - width_ext;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (acc) begin
         case (ph_eff)
            tgasd_pkg::PH_HEADER: begin
               phase_in = tgasd_pkg::PH_HEADER;
               if (hdr_end) begin
                  if (hdr_err != tgasd_pkg::STATUS_PIXEL || image_empty) begin
                     phase_in = tgasd_pkg::PH_DONE;
                  end else if (id_length_ff != 8'd0) begin
                     phase_in = tgasd_pkg::PH_SKIPID;
                  end else begin
                     phase_in = data_phase;
                  end
               end
            end
            tgasd_pkg::PH_SKIPID: begin
               if (skip_done) begin
                  phase_in = data_phase;
               end
            end
            tgasd_pkg::PH_PKTHDR: begin
               phase_in = tgasd_pkg::PH_PIXEL;
            end
            tgasd_pkg::PH_PIXEL: begin
               if (pix_final) begin
                  if (run_last) begin
                     phase_in = tgasd_pkg::PH_DONE;
                  end else if (is_rle && (packet_repeat_ff || pkt_dec == 8'd0)) begin
                     phase_in = tgasd_pkg::PH_PKTHDR;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      byte_index_in       = byte_index_ff;
      id_length_in        = id_length_ff;
      colormap_kind_in    = colormap_kind_ff;
      image_type_in       = image_type_ff;
      pixel_depth_in      = pixel_depth_ff;
      top_down_in         = top_down_ff;
      image_width_in      = image_width_ff;
      image_height_in     = image_height_ff;
      pixel_bytes_in      = pixel_bytes_ff;
      pixel_byte_count_in = pixel_byte_count_ff;
      packet_repeat_in    = packet_repeat_ff;
      packet_left_in      = packet_left_ff;
      cur_x_in            = cur_x_ff;
      cur_y_in            = cur_y_ff;
      pixels_left_in      = pixels_left_ff;

      res_valid      = 1'b0;
      res            = '0;
      res.status     = tgasd_pkg::STATUS_PIXEL;
      div_req.start    = 1'b0;
      div_req.dividend = col_sum;
      div_req.divisor  = image_width_ff;

      // cursor update after a long run
      if (div_rsp.done) begin
         cur_x_in = div_rsp.remainder;
         if (top_down_ff) begin
            cur_y_in = cur_y_ff + {8'd0, div_rsp.quotient};
         end else begin
            cur_y_in = cur_y_ff - {8'd0, div_rsp.quotient};
         end
      end

      if (acc) begin
         case (ph_eff)
            tgasd_pkg::PH_HEADER: begin
               byte_index_in = bi_next;
               case (bi_eff)
                  tgasd_pkg::HDR_ID_LENGTH: id_length_in     = req_tdata;
                  tgasd_pkg::HDR_CMAP_KIND: colormap_kind_in = req_tdata;
                  tgasd_pkg::HDR_IMG_TYPE:  image_type_in    = req_tdata;
                  tgasd_pkg::HDR_WIDTH_LO:  image_width_in   = {image_width_ff[15:8], req_tdata};
                  tgasd_pkg::HDR_WIDTH_HI:  image_width_in   = {req_tdata, image_width_ff[7:0]};
                  tgasd_pkg::HDR_HEIGHT_LO: image_height_in  = {image_height_ff[15:8], req_tdata};
                  tgasd_pkg::HDR_HEIGHT_HI: image_height_in  = {req_tdata, image_height_ff[7:0]};
                  tgasd_pkg::HDR_DEPTH:     pixel_depth_in   = req_tdata;
                  tgasd_pkg::HDR_DESC:      top_down_in = req_tdata[tgasd_pkg::DESC_TOP_DOWN_BIT];
                  default: begin
                     byte_index_in = bi_next;
                  end
               endcase
               if (hdr_end) begin
                  if (hdr_err != tgasd_pkg::STATUS_PIXEL) begin
                     res_valid  = 1'b1;
                     res.status = hdr_err;
                     res.last   = 1'b1;
                  end else begin
                     pixels_left_in      = 32'(image_width_ff) * 32'(image_height_ff);
                     cur_x_in            = 16'd0;
                     // descriptor is the byte on the bus now
                     cur_y_in            = req_tdata[tgasd_pkg::DESC_TOP_DOWN_BIT] ?
                                           16'd0 : (image_height_ff - 16'd1);
                     pixel_byte_count_in = 2'd0;
                     pixel_bytes_in      = 24'd0;
                     packet_repeat_in    = 1'b0;
                     packet_left_in      = 8'd0;
                     byte_index_in       = 8'd0;
                  end
               end
            end
            tgasd_pkg::PH_SKIPID: begin
               byte_index_in = bi_next;
               if (skip_done) begin
                  packet_repeat_in    = 1'b0;
                  packet_left_in      = 8'd0;
                  pixel_byte_count_in = 2'd0;
               end
            end
            tgasd_pkg::PH_PKTHDR: begin
               packet_repeat_in    = req_tdata[7];
               packet_left_in      = {1'b0, req_tdata[6:0]} + 8'd1;
               pixel_byte_count_in = 2'd0;
            end
            tgasd_pkg::PH_PIXEL: begin
               if (!pix_final) begin
                  case (pixel_byte_count_ff)
                     2'd0:    pixel_bytes_in[7:0]   = req_tdata;
                     2'd1:    pixel_bytes_in[15:8]  = req_tdata;
                     default: pixel_bytes_in[23:16] = req_tdata;
                  endcase
                  pixel_byte_count_in = pixel_byte_count_ff + 2'd1;
               end else begin
                  res_valid      = 1'b1;
                  res.status     = tgasd_pkg::STATUS_PIXEL;
                  res.pixel_argb = tgasd_pkg::convert_pixel(pixel_depth_ff, pixel_bytes_ff,
                                                            req_tdata);
                  res.pos_x      = cur_x_ff;
                  res.pos_y      = cur_y_ff;
                  res.repeat_res = run_len;
                  res.last       = run_last;
                  pixel_byte_count_in = 2'd0;
                  pixels_left_in = run_last ? 32'd0 : (pixels_left_ff - {24'd0, run_len});
                  if (!run_last) begin
                     // same row, one row end, or several via the divider
                     if (col_sum < width_ext) begin
                        cur_x_in = col_sum[15:0];
                     end else if (col_wrap < width_ext) begin
                        cur_x_in = col_wrap[15:0];
                        cur_y_in = top_down_ff ? (cur_y_ff + 16'd1) : (cur_y_ff - 16'd1);
                     end else begin
                        div_req.start = 1'b1;
                     end
                     if (is_rle && !packet_repeat_ff) begin
                        packet_left_in = pkt_dec;
                     end
                  end
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   // output register with skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (res_valid) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= tgasd_pkg::PH_IDLE;
         byte_index_ff       <= 8'd0;
         id_length_ff        <= 8'd0;
         colormap_kind_ff    <= 8'd0;
         image_type_ff       <= 8'd0;
         pixel_depth_ff      <= 8'd0;
         top_down_ff         <= 1'b0;
         image_width_ff      <= 16'd0;
         image_height_ff     <= 16'd0;
         pixel_bytes_ff      <= 24'd0;
         pixel_byte_count_ff <= 2'd0;
         packet_repeat_ff    <= 1'b0;
         packet_left_ff      <= 8'd0;
         cur_x_ff            <= 16'd0;
         cur_y_ff            <= 16'd0;
         pixels_left_ff      <= 32'd0;
         out_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         phase_ff            <= phase_in;
         byte_index_ff       <= byte_index_in;
         id_length_ff        <= id_length_in;
         colormap_kind_ff    <= colormap_kind_in;
         image_type_ff       <= image_type_in;
         pixel_depth_ff      <= pixel_depth_in;
         top_down_ff         <= top_down_in;
         image_width_ff      <= image_width_in;
         image_height_ff     <= image_height_in;
         pixel_bytes_ff      <= pixel_bytes_in;
         pixel_byte_count_ff <= pixel_byte_count_in;
         packet_repeat_ff    <= packet_repeat_in;
         packet_left_ff      <= packet_left_in;
         cur_x_ff            <= cur_x_in;
         cur_y_ff            <= cur_y_in;
         pixels_left_ff      <= pixels_left_in;
         out_valid_ff        <= out_valid_in;
         skid_valid_ff       <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_data_ff.repeat_res, out_data_ff.pos_y,
                        out_data_ff.pos_x, out_data_ff.pixel_argb};
   assign rsp_tuser  = out_data_ff.status;
   assign rsp_tlast  = out_data_ff.last;

endmodule

`default_nettype wire

/* tb/sv/tga_image_stream_decoder_tb.sv */
// self-checking testbench for the tga image stream decoder: crafted tga files go
// in one byte per transfer and every result is checked by a scoreboard class
// depends on tgasd_pkg and the tga_image_stream_decoder top level
module tga_image_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned RANDOM_ITEMS   = 700;
   localparam int unsigned MAX_FILE_BYTES = 600;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned DRAIN_CYCLES   = 20;

   // decoder model plus the list of results it still owes
   class tga_scoreboard;
      tgasd_pkg::tgasd_phase_type  phase;
      logic [7:0]                  byte_idx;
      logic [7:0]                  id_len;
      logic [7:0]                  cmap_kind;
      logic [7:0]                  img_type;
      logic [7:0]                  depth;
      logic                        top_down;
      logic [15:0]                 width;
      logic [15:0]                 height;
      logic [23:0]                 low_bytes;
      logic [1:0]                  byte_cnt;
      logic                        run_repeat;
      logic [7:0]                  run_left;
      logic [15:0]                 cur_x;
      logic [15:0]                 cur_y;
      logic [31:0]                 img_left;
      tgasd_pkg::tgasd_result_type expected_q[$];
      int unsigned                 error_count;
      int unsigned                 result_count;

      function new();
         phase        = tgasd_pkg::PH_IDLE;
         byte_idx     = '0;
         id_len       = '0;
         cmap_kind    = '0;
         img_type     = '0;
         depth        = '0;
         top_down     = 1'b0;
         width        = '0;
         height       = '0;
         low_bytes    = '0;
         byte_cnt     = '0;
         run_repeat   = 1'b0;
         run_left     = '0;
         cur_x        = '0;
         cur_y        = '0;
         img_left     = '0;
         error_count  = 0;
         result_count = 0;
      endfunction

      function void open_data();
         phase      = (img_type == tgasd_pkg::TYPE_RLE) ? tgasd_pkg::PH_PKTHDR
                                                        : tgasd_pkg::PH_PIXEL;
         run_repeat = 1'b0;
         run_left   = '0;
         byte_cnt   = '0;
      endfunction

      // take one accepted byte; returns 1 when the parser actually used it
      function bit note_byte(logic [7:0] b, logic start);
         bit                          used;
         tgasd_pkg::tgasd_status_type err;
         tgasd_pkg::tgasd_result_type res;
         int unsigned                 psize;
         int unsigned                 n;
         int unsigned                 t;
         int unsigned                 rows;
         logic [31:0]                 px;
         logic                        is_last;
         if (start) begin
            phase    = tgasd_pkg::PH_HEADER;
            byte_idx = 8'd0;
         end
         used = (phase != tgasd_pkg::PH_IDLE) && (phase != tgasd_pkg::PH_DONE);
         case (phase)
            tgasd_pkg::PH_HEADER: begin
               case (byte_idx)
                  tgasd_pkg::HDR_ID_LENGTH: id_len = b;
                  tgasd_pkg::HDR_CMAP_KIND: cmap_kind = b;
                  tgasd_pkg::HDR_IMG_TYPE:  img_type = b;
                  tgasd_pkg::HDR_WIDTH_LO:  width[7:0] = b;
                  tgasd_pkg::HDR_WIDTH_HI:  width[15:8] = b;
                  tgasd_pkg::HDR_HEIGHT_LO: height[7:0] = b;
                  tgasd_pkg::HDR_HEIGHT_HI: height[15:8] = b;
                  tgasd_pkg::HDR_DEPTH:     depth = b;
                  tgasd_pkg::HDR_DESC:      top_down = b[tgasd_pkg::DESC_TOP_DOWN_BIT];
                  default: ;
               endcase
               byte_idx = byte_idx + 8'd1;
               if (byte_idx == tgasd_pkg::HDR_LENGTH) begin
                  // checks go type, then depth, then colour map
                  err = tgasd_pkg::STATUS_PIXEL;
                  if (img_type != tgasd_pkg::TYPE_RAW && img_type != tgasd_pkg::TYPE_RLE)
                     err = tgasd_pkg::STATUS_BAD_TYPE;
                  else if (depth != tgasd_pkg::DEPTH_16 && depth != tgasd_pkg::DEPTH_24
                           && depth != tgasd_pkg::DEPTH_32)
                     err = tgasd_pkg::STATUS_BAD_BPP;
                  else if (cmap_kind != 8'd0)
                     err = tgasd_pkg::STATUS_CMAP;
                  if (err != tgasd_pkg::STATUS_PIXEL) begin
                     phase          = tgasd_pkg::PH_DONE;
                     res.status     = err;
                     res.pixel_argb = '0;
                     res.pos_x      = '0;
                     res.pos_y      = '0;
                     res.repeat_res = '0;
                     res.last       = 1'b1;
                     expected_q.push_back(res);
                  end else begin
                     img_left  = 32'(width) * 32'(height);
                     cur_x     = '0;
                     cur_y     = top_down ? 16'd0 : height - 16'd1;
                     byte_cnt  = '0;
                     low_bytes = '0;
                     if (img_left == 0) begin
                        phase = tgasd_pkg::PH_DONE;
                     end else if (id_len != 8'd0) begin
                        phase    = tgasd_pkg::PH_SKIPID;
                        byte_idx = 8'd0;
                     end else begin
                        open_data();
                     end
                  end
               end
            end
            tgasd_pkg::PH_SKIPID: begin
               byte_idx = byte_idx + 8'd1;
               if (byte_idx == id_len) open_data();
            end
            tgasd_pkg::PH_PKTHDR: begin
               run_repeat = b[7];
               run_left   = {1'b0, b[6:0]} + 8'd1;
               byte_cnt   = '0;
               phase      = tgasd_pkg::PH_PIXEL;
            end
            tgasd_pkg::PH_PIXEL: begin
               psize = (depth == tgasd_pkg::DEPTH_16) ? 2 :
                       (depth == tgasd_pkg::DEPTH_24) ? 3 : 4;
               if (byte_cnt + 1 < psize) begin
                  low_bytes[8*byte_cnt +: 8] = b;
                  byte_cnt = byte_cnt + 2'd1;
               end else begin
                  if (depth == tgasd_pkg::DEPTH_16) begin
                     // 5-5-5, each channel moved to the top of its byte
                     px = 32'hff00_0000
                        | (((32'(b) >> 2) & 32'h1f) << 19)
                        | ((((32'(low_bytes[7:0]) >> 5) & 32'h7)
                            | ((32'(b) & 32'h3) << 3)) << 11)
                        | ((32'(low_bytes[7:0]) & 32'h1f) << 3);
                  end else if (depth == tgasd_pkg::DEPTH_24) begin
                     px = {8'hff, b, low_bytes[15:0]};
                  end else begin
                     // fully transparent pixels collapse to zero
                     px = (b == 8'd0) ? 32'd0 : {b, low_bytes};
                  end
                  byte_cnt = '0;
                  n = 1;
                  if (img_type == tgasd_pkg::TYPE_RLE && run_repeat) begin
                     n = run_left;
                     if (n > img_left) n = img_left;
                  end
                  if (n == 0) n = 1;
                  is_last        = (img_left <= n);
                  res.status     = tgasd_pkg::STATUS_PIXEL;
                  res.pixel_argb = px;
                  res.pos_x      = cur_x;
                  res.pos_y      = cur_y;
                  res.repeat_res = n[7:0];
                  res.last       = is_last;
                  expected_q.push_back(res);
                  // move the cursor in raster order, rows wrap mod 2^16
                  if (width != 16'd0) begin
                     t     = cur_x + n;
                     rows  = t / width;
                     cur_x = 16'(t % width);
                     cur_y = top_down ? cur_y + 16'(rows) : cur_y - 16'(rows);
                  end
                  img_left = is_last ? 32'd0 : img_left - n;
                  if (is_last) begin
                     phase = tgasd_pkg::PH_DONE;
                  end else if (img_type == tgasd_pkg::TYPE_RLE) begin
                     if (run_repeat) begin
                        phase = tgasd_pkg::PH_PKTHDR;
                     end else begin
                        run_left = run_left - 8'd1;
                        if (run_left == 8'd0) phase = tgasd_pkg::PH_PKTHDR;
                     end
                  end
               end
            end
            default: ;
         endcase
         return used;
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("result %0d: %s is %h, should be %h", result_count, what, got, want);
         error_count++;
      endtask

      task check_result(logic [71:0] data, logic [1:0] user, logic tlast);
         tgasd_pkg::tgasd_result_type want;
         result_count++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected transfer, status", 32'(user), 32'd0);
         end else begin
            want = expected_q.pop_front();
            if (user !== want.status)
               report_mismatch("status", 32'(user), 32'(want.status));
            if (data[31:0] !== want.pixel_argb)
               report_mismatch("pixel_argb", data[31:0], want.pixel_argb);
            if (data[47:32] !== want.pos_x)
               report_mismatch("pos_x", 32'(data[47:32]), 32'(want.pos_x));
            if (data[63:48] !== want.pos_y)
               report_mismatch("pos_y", 32'(data[63:48]), 32'(want.pos_y));
            if (data[71:64] !== want.repeat_res)
               report_mismatch("repeat_res", 32'(data[71:64]), 32'(want.repeat_res));
            if (tlast !== want.last)
               report_mismatch("last", 32'(tlast), 32'(want.last));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // data_byte
   logic [0:0]  req_tuser = 1'b0;    // file_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;           // pixel_argb, pos_x, pos_y, repeat_res
   logic [1:0]  rsp_tuser;           // status
   logic        rsp_tlast;           // last

   tga_scoreboard sb = new();

   bit          calm = 1'b0;         // no idling on either side while set
   bit          hold_request = 1'b0; // asks the receiver for a long hold-off
   int unsigned hold_left = 0;
   int unsigned parsed_bytes = 0;
   logic [7:0]  file_bytes[$];

   tga_image_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one byte transfer, with an occasional idle gap in front of it
   task automatic send_byte(input logic [7:0] data, input logic start);
      int unsigned gap;
      if (!calm && $urandom_range(99) < 9) begin
         gap = $urandom_range(4, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= start;
      // ready is stable at the falling edge, the transfer lands on the next rise
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      if (sb.note_byte(data, start)) parsed_bytes++;
   endtask

   // stop offering bytes until every owed result has been taken
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   // one random pixel, the alpha byte of a 32-bit pixel is often zero
   function automatic void push_pixel(int unsigned psize);
      logic [7:0] b;
      for (int unsigned i = 0; i < psize; i++) begin
         b = 8'($urandom);
         if (psize == 4 && i == 3 && $urandom_range(3) == 0) b = 8'd0;
         file_bytes.push_back(b);
      end
   endfunction

   // builds a file from the header fields and random pixel data, then sends
   // it; cut stops the file early, garbage appends bytes past the image
   task automatic send_file(input logic [7:0] id_len, input logic [7:0] cmap,
                            input logic [7:0] itype, input logic [7:0] depth,
                            input logic [7:0] desc, input logic [15:0] w,
                            input logic [15:0] h, input int unsigned cut,
                            input int unsigned garbage);
      int unsigned total;
      int unsigned covered;
      int unsigned psize;
      int unsigned run;
      int unsigned limit;
      logic [7:0]  pkt;
      file_bytes.delete();
      file_bytes.push_back(id_len);
      file_bytes.push_back(cmap);
      file_bytes.push_back(itype);
      repeat (9) file_bytes.push_back(8'($urandom));
      file_bytes.push_back(w[7:0]);
      file_bytes.push_back(w[15:8]);
      file_bytes.push_back(h[7:0]);
      file_bytes.push_back(h[15:8]);
      file_bytes.push_back(depth);
      file_bytes.push_back(desc);
      repeat (id_len) file_bytes.push_back(8'($urandom));
      total   = 32'(w) * 32'(h);
      psize   = (depth == tgasd_pkg::DEPTH_16) ? 2 :
                (depth == tgasd_pkg::DEPTH_24) ? 3 : 4;
      covered = 0;
      while (covered < total && file_bytes.size() < MAX_FILE_BYTES
             && (itype == tgasd_pkg::TYPE_RAW || itype == tgasd_pkg::TYPE_RLE)) begin
         if (itype == tgasd_pkg::TYPE_RLE) begin
            // mostly short packets, some long runs that cross rows
            run = ($urandom_range(99) < 20) ? $urandom_range(127) : $urandom_range(7);
            pkt = {1'($urandom_range(1)), 7'(run)};
            file_bytes.push_back(pkt);
            if (pkt[7]) push_pixel(psize);
            else repeat (run + 1) push_pixel(psize);
            covered += run + 1;
         end else begin
            push_pixel(psize);
            covered++;
         end
      end
      repeat (garbage) file_bytes.push_back(8'($urandom));
      limit = (cut != 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
      for (int unsigned k = 0; k < limit; k++)
         send_byte(file_bytes[k], k == 0);
   endtask

   // receiver: random back-pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 9);
      end
   end

   // result transfers are picked up at the falling edge, where all is settled
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // watchdog
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tga_image_stream_decoder: mismatch");
      $finish;
   end

   initial begin
      int unsigned fc;
      int unsigned r;
      int unsigned cut;
      int unsigned garbage;
      logic [7:0]  itype;
      logic [7:0]  depth;
      logic [7:0]  cmap;
      logic [7:0]  id_len;
      logic [15:0] w;
      logic [15:0] h;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bytes before any file start are dropped
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b0);
      // header errors: bad type beats bad depth and colour map
      send_file(8'd0, 8'd1, 8'd0, 8'd8, 8'h00, 16'd2, 16'd2, 0, 2);
      // bad depth beats colour map
      send_file(8'd0, 8'd1, tgasd_pkg::TYPE_RLE, 8'd15, 8'h00, 16'd2, 16'd2, 0, 0);
      // colour map present on an otherwise good header
      send_file(8'd0, 8'hff, tgasd_pkg::TYPE_RAW, tgasd_pkg::DEPTH_32, 8'h00,
                16'd1, 16'd1, 0, 0);
      // 32-bit raw, top-down, bytes after the last pixel are dropped
      send_file(8'd0, 8'd0, tgasd_pkg::TYPE_RAW, tgasd_pkg::DEPTH_32, 8'h20,
                16'd4, 16'd2, 0, 3);
      // 16-bit rle, bottom-up, short id field
      send_file(8'd2, 8'd0, tgasd_pkg::TYPE_RLE, tgasd_pkg::DEPTH_16, 8'h00,
                16'd3, 16'd3, 0, 2);
      // empty images give nothing
      send_file(8'd0, 8'd0, tgasd_pkg::TYPE_RLE, tgasd_pkg::DEPTH_24, 8'h00,
                16'd0, 16'd5, 0, 2);
      send_file(8'd0, 8'd0, tgasd_pkg::TYPE_RAW, tgasd_pkg::DEPTH_24, 8'h20,
                16'd5, 16'd0, 0, 2);
      // longest id field
      send_file(8'hff, 8'd0, tgasd_pkg::TYPE_RAW, tgasd_pkg::DEPTH_24, 8'hff,
                16'd1, 16'd1, 0, 0);
      // largest image both ways up, each cut short by the next file start
      send_file(8'd0, 8'd0, tgasd_pkg::TYPE_RLE, tgasd_pkg::DEPTH_24, 8'h00,
                16'hffff, 16'hffff, 60, 0);
      send_file(8'd0, 8'd0, tgasd_pkg::TYPE_RLE, tgasd_pkg::DEPTH_32, 8'h20,
                16'hffff, 16'hffff, 60, 0);
      // restart in the middle of a header
      send_file(8'd0, 8'd0, tgasd_pkg::TYPE_RAW, tgasd_pkg::DEPTH_16, 8'h00,
                16'd2, 16'd2, 9, 0);
      // long receiver hold-off while bytes keep coming
      hold_request = 1'b1;
      send_file(8'd0, 8'd0, tgasd_pkg::TYPE_RAW, tgasd_pkg::DEPTH_16, 8'h20,
                16'd8, 16'd8, 0, 0);
      wait_for_results();

      // random files, mostly well formed
      parsed_bytes = 0;
      fc = 0;
      while (parsed_bytes < RANDOM_ITEMS) begin
         calm = (fc >= 3 && fc < 8);
         if (fc == 2 || fc == 8) wait_for_results();
         r = $urandom_range(99);
         itype = (r < 40) ? tgasd_pkg::TYPE_RAW :
                 (r < 82) ? tgasd_pkg::TYPE_RLE : 8'($urandom);
         case ($urandom_range(2))
            0: depth = tgasd_pkg::DEPTH_16;
            1: depth = tgasd_pkg::DEPTH_24;
            default: depth = tgasd_pkg::DEPTH_32;
         endcase
         if ($urandom_range(99) < 15) depth = 8'($urandom);
         cmap = ($urandom_range(99) < 90) ? 8'd0 : 8'($urandom_range(255, 1));
         r = $urandom_range(99);
         id_len = (r < 60) ? 8'd0 : (r < 90) ? 8'($urandom_range(4, 1))
                                             : 8'($urandom_range(255));
         r = $urandom_range(99);
         w = (r < 8) ? 16'd0 : (r < 70) ? 16'($urandom_range(4, 1))
           : (r < 96) ? 16'($urandom_range(20, 5)) : 16'($urandom);
         r = $urandom_range(99);
         h = (r < 6) ? 16'd0 : (r < 80) ? 16'($urandom_range(4, 1))
                                        : 16'($urandom_range(10, 5));
         cut = ($urandom_range(99) < 10) ? $urandom_range(60, 1) : 0;
         garbage = ($urandom_range(99) < 30) ? $urandom_range(4, 1) : 0;
         send_file(id_len, cmap, itype, depth, 8'($urandom), w, h, cut, garbage);
         fc++;
      end
      calm = 1'b0;

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
         $display("tga_image_stream_decoder: match");
      end else begin
         $display("tga_image_stream_decoder: mismatch");
      end
      $finish;
   end
endmodule

/* sim.f */
sv/tgasd_pkg.sv
sv/tgasd_row_div.sv
sv/tga_image_stream_decoder.sv
tb/sv/tga_image_stream_decoder_tb.sv
